// ===== rtl/icc_pkg.sv =====
// Package for the ISP color correction block: widths, register codes,
// reset values and payload types shared by the interfaces and the top level.
// No dependencies.
package icc_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int PIXEL_MAX      = (1 << PIXEL_BITS) - 1;
    localparam int NUM_CHAN       = 3;
    localparam int GAIN_BITS      = 16;
    localparam int COEF_BITS      = 16;
    localparam int ROW_BITS       = NUM_CHAN * COEF_BITS;
    localparam int CFG_DATA_BITS  = ROW_BITS;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TABLE_BITS     = 8;
    localparam int TABLE_DEPTH    = 1 << TABLE_BITS;
    localparam int FRAC_BITS      = 12;
    localparam int SUM_FRAC       = 2 * FRAC_BITS;
    localparam int WB_BITS        = PIXEL_BITS + GAIN_BITS;
    localparam int PROD_BITS      = COEF_BITS + WB_BITS + 1;
    localparam int SUM_BITS       = PROD_BITS + 2;
    localparam int ROUND_BITS     = SUM_BITS - SUM_FRAC;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GAIN_RED     = 3'd0,
        CFG_GAIN_GREEN   = 3'd1,
        CFG_GAIN_BLUE    = 3'd2,
        CFG_ROW_RED      = 3'd3,
        CFG_ROW_GREEN    = 3'd4,
        CFG_ROW_BLUE     = 3'd5,
        CFG_GAMMA_ENABLE = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_CORRECT     = 1'b0,
        OP_TABLE_WRITE = 1'b1
    } op_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [TABLE_BITS-1:0] tbl_idx_t;
    typedef logic [GAIN_BITS-1:0]  gain_t;
    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [WB_BITS-1:0]    wb_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam gain_t GAIN_RESET      = 16'd4096;
    localparam row_t  ROW_RED_RESET   = 48'h0000_0000_1000;
    localparam row_t  ROW_GREEN_RESET = 48'h0000_1000_0000;
    localparam row_t  ROW_BLUE_RESET  = 48'h1000_0000_0000;

endpackage

// ===== rtl/icc_if.sv =====
// Stream interfaces of the ISP color correction block: pixel/table-write
// items in, corrected pixels out. Depends on icc_pkg.
interface icc_pixel_if;
    logic              valid;
    logic              ready;
    logic              operation;
    icc_pkg::pixel_t   pixel_red;
    icc_pkg::pixel_t   pixel_green;
    icc_pkg::pixel_t   pixel_blue;
    icc_pkg::tbl_idx_t table_index;
    icc_pkg::pixel_t   table_value;

    modport source (output valid, operation, pixel_red, pixel_green, pixel_blue,
                    table_index, table_value, input ready);
    modport sink (input valid, operation, pixel_red, pixel_green, pixel_blue,
                  table_index, table_value, output ready);
endinterface

interface icc_result_if;
    logic            valid;
    logic            ready;
    icc_pkg::pixel_t out_red;
    icc_pkg::pixel_t out_green;
    icc_pkg::pixel_t out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== rtl/isp_color_correction.sv =====
// ISP color correction top level: white balance, 3x3 color matrix, gamma table.
// Depends on icc_pkg and the interfaces in icc_if.sv.
//
// Usage:
//   pixels  : valid/ready input. operation = correct carries one RGB pixel;
//             operation = table write stores table_value at table_index in the
//             gamma table and produces no result.
//   results : valid/ready output, one corrected RGB pixel per corrected input.
//   cfg_*   : write port for gains, matrix rows and gamma enable; write only
//             while the block is idle.
// Pipeline: four register stages (gain multiply, matrix multiply,
// sum/round/saturate, gamma table read). Throughput: one item per clock while
// results are taken, set by the four-stage pipeline and a per-channel copy of
// the gamma table so all three channels read it in the same cycle.
// Stall: each stage holds its item while the one ahead is full and stalled;
// bubbles close up, so input is taken while a result waits if a stage is free.
// Reset: valid bits clear, gains reset to 1.0, matrix to identity, gamma off.
// The gamma table is undefined until written.
module isp_color_correction (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [icc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [icc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    icc_pixel_if.sink                            pixels,
    icc_result_if.source                         results
);

    localparam int NC = icc_pkg::NUM_CHAN;

    icc_pkg::gain_t    gain_reg [NC];
    icc_pkg::row_t     row_reg [NC];
    logic              gamma_en_reg;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              adv1, adv2, adv3, adv4;
    logic              op1_reg, op2_reg, op3_reg;
    icc_pkg::tbl_idx_t idx1_reg, idx2_reg, idx3_reg;
    icc_pkg::pixel_t   val1_reg, val2_reg, val3_reg;

    icc_pkg::pixel_t   pix_in [NC];
    icc_pkg::wb_t      wb_next [NC];
    icc_pkg::wb_t      wb1_reg [NC];
    icc_pkg::prod_t    prod_next [NC][NC];
    icc_pkg::prod_t    prod2_reg [NC][NC];
    icc_pkg::pixel_t   lvl_next [NC];
    icc_pkg::pixel_t   lvl3_reg [NC];
    icc_pkg::pixel_t   lvl4_reg [NC];
    logic              pos_next [NC];
    logic              pos3_reg [NC];
    logic              pos4_reg [NC];
    icc_pkg::pixel_t   gam4_reg [NC];
    logic              tbl_wr;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0]  <= icc_pkg::GAIN_RESET;
            gain_reg[1]  <= icc_pkg::GAIN_RESET;
            gain_reg[2]  <= icc_pkg::GAIN_RESET;
            row_reg[0]   <= icc_pkg::ROW_RED_RESET;
            row_reg[1]   <= icc_pkg::ROW_GREEN_RESET;
            row_reg[2]   <= icc_pkg::ROW_BLUE_RESET;
            gamma_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                icc_pkg::CFG_GAIN_RED:
                    gain_reg[0] <= cfg_data[icc_pkg::GAIN_BITS-1:0];
                icc_pkg::CFG_GAIN_GREEN:
                    gain_reg[1] <= cfg_data[icc_pkg::GAIN_BITS-1:0];
                icc_pkg::CFG_GAIN_BLUE:
                    gain_reg[2] <= cfg_data[icc_pkg::GAIN_BITS-1:0];
                icc_pkg::CFG_ROW_RED:
                    row_reg[0] <= cfg_data[icc_pkg::ROW_BITS-1:0];
                icc_pkg::CFG_ROW_GREEN:
                    row_reg[1] <= cfg_data[icc_pkg::ROW_BITS-1:0];
                icc_pkg::CFG_ROW_BLUE:
                    row_reg[2] <= cfg_data[icc_pkg::ROW_BITS-1:0];
                icc_pkg::CFG_GAMMA_ENABLE:
                    gamma_en_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // Advance when the stage is empty or the stage ahead moves
    assign adv4 = !v4_reg || results.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign pixels.ready = adv1;

    assign tbl_wr = adv4 && v3_reg && (op3_reg == icc_pkg::OP_TABLE_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= pixels.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg && (op3_reg == icc_pkg::OP_CORRECT);
            end
        end
    end

    assign pix_in[0] = pixels.pixel_red;
    assign pix_in[1] = pixels.pixel_green;
    assign pix_in[2] = pixels.pixel_blue;

    // White balance
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            wb_next[c] = icc_pkg::WB_BITS'(pix_in[c]) * icc_pkg::WB_BITS'(gain_reg[c]);
        end
    end

    // Matrix products
    always_comb
    begin
        logic signed [icc_pkg::COEF_BITS-1:0] coef;
        logic signed [icc_pkg::WB_BITS:0]     wbs;
        coef = '0;
        wbs  = '0;
        for (int r = 0; r < NC; r++)
        begin
            for (int c = 0; c < NC; c++)
            begin
                coef = row_reg[r][c*icc_pkg::COEF_BITS +: icc_pkg::COEF_BITS];
                wbs  = {1'b0, wb1_reg[c]};
                prod_next[r][c] = icc_pkg::PROD_BITS'(coef) * icc_pkg::PROD_BITS'(wbs);
            end
        end
    end

    // Sum, round half up, saturate; a sum that is not positive bypasses gamma
    always_comb
    begin
        logic signed [icc_pkg::SUM_BITS-1:0] sum;
        logic signed [icc_pkg::SUM_BITS-1:0] rsum;
        logic [icc_pkg::ROUND_BITS-1:0]      rnd;
        sum  = '0;
        rsum = '0;
        rnd  = '0;
        for (int r = 0; r < NC; r++)
        begin
            sum = icc_pkg::SUM_BITS'(prod2_reg[r][0]) + icc_pkg::SUM_BITS'(prod2_reg[r][1])
                + icc_pkg::SUM_BITS'(prod2_reg[r][2]);
            rsum = sum + icc_pkg::SUM_BITS'(1 << (icc_pkg::SUM_FRAC - 1));
            rnd  = rsum[icc_pkg::SUM_BITS-1:icc_pkg::SUM_FRAC];
            if (sum <= 0)
            begin
                lvl_next[r] = '0;
                pos_next[r] = 1'b0;
            end
            else if (rnd > icc_pkg::ROUND_BITS'(icc_pkg::PIXEL_MAX))
            begin
                lvl_next[r] = icc_pkg::PIXEL_BITS'(icc_pkg::PIXEL_MAX);
                pos_next[r] = 1'b1;
            end
            else
            begin
                lvl_next[r] = rnd[icc_pkg::PIXEL_BITS-1:0];
                pos_next[r] = 1'b1;
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            op1_reg  <= pixels.operation;
            idx1_reg <= pixels.table_index;
            val1_reg <= pixels.table_value;
            wb1_reg  <= wb_next;
        end
        if (adv2)
        begin
            op2_reg   <= op1_reg;
            idx2_reg  <= idx1_reg;
            val2_reg  <= val1_reg;
            prod2_reg <= prod_next;
        end
        if (adv3)
        begin
            op3_reg  <= op2_reg;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;
            lvl3_reg <= lvl_next;
            pos3_reg <= pos_next;
        end
        if (adv4)
        begin
            lvl4_reg <= lvl3_reg;
            pos4_reg <= pos3_reg;
        end
    end

    // Gamma table, one copy per channel
    for (genvar c = 0; c < NC; c++)
    begin : g_gamma
        icc_pkg::pixel_t gamma_mem [icc_pkg::TABLE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (tbl_wr)
            begin
                gamma_mem[idx3_reg] <= val3_reg;
            end
            if (adv4)
            begin
                gam4_reg[c] <= gamma_mem[lvl3_reg[c][icc_pkg::TABLE_BITS-1:0]];
            end
        end
    end

    assign results.valid     = v4_reg;
    assign results.out_red   = gamma_en_reg ? (pos4_reg[0] ? gam4_reg[0] : '0) : lvl4_reg[0];
    assign results.out_green = gamma_en_reg ? (pos4_reg[1] ? gam4_reg[1] : '0) : lvl4_reg[1];
    assign results.out_blue  = gamma_en_reg ? (pos4_reg[2] ? gam4_reg[2] : '0) : lvl4_reg[2];

endmodule

// ===== tb/tb.sv =====
// Testbench for isp_color_correction: pixel and gamma-table items go in with random
// gaps on both handshakes; corrected pixels are checked against a predictor or plan.
// Depends on icc_pkg, the stream interfaces in icc_if.sv and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icc_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NONE = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_DIRECTED  = 21;

    typedef struct packed {
        pixel_t red;
        pixel_t green;
        pixel_t blue;
    } rgb_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_REG
    } step_kind_t;

    // item: a/b/c = red/green/blue, or index/value for a table write
    // register write: a = register index, data = write data
    typedef struct packed {
        step_kind_t               kind;
        op_t                      op;
        pixel_t                   a;
        pixel_t                   b;
        pixel_t                   c;
        logic                     known;
        rgb_t                     want;
        logic [CFG_DATA_BITS-1:0] data;
    } step_t;

    localparam step_t DIRECTED_PLAN [NUM_DIRECTED] = '{
        '{STEP_REG, OP_CORRECT, 8'(CFG_NONE), 8'd0, 8'd0, 1'b0, 24'd0, 48'hFFFF_FFFF_FFFF},
        '{STEP_ITEM, OP_CORRECT, 8'd0, 8'd0, 8'd0, 1'b1, {8'd0, 8'd0, 8'd0}, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd255, 8'd255, 8'd255, 1'b1, {8'd255, 8'd255, 8'd255}, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd1, 8'd128, 8'd254, 1'b1, {8'd1, 8'd128, 8'd254}, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd170, 8'd85, 8'd15, 1'b1, {8'd170, 8'd85, 8'd15}, 48'd0},
        '{STEP_ITEM, OP_TABLE_WRITE, 8'd0, 8'd255, 8'd0, 1'b0, 24'd0, 48'd0},
        '{STEP_ITEM, OP_TABLE_WRITE, 8'd255, 8'd0, 8'd0, 1'b0, 24'd0, 48'd0},
        '{STEP_ITEM, OP_TABLE_WRITE, 8'd128, 8'd170, 8'd0, 1'b0, 24'd0, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd254, 8'd127, 8'd1, 1'b1, {8'd254, 8'd127, 8'd1}, 48'd0},
        '{STEP_REG, OP_CORRECT, 8'(CFG_GAIN_RED), 8'd0, 8'd0, 1'b0, 24'd0, 48'hFFFF_FFFF_0000},
        '{STEP_ITEM, OP_CORRECT, 8'd200, 8'd100, 8'd50, 1'b1, {8'd0, 8'd100, 8'd50}, 48'd0},
        '{STEP_REG, OP_CORRECT, 8'(CFG_GAIN_RED), 8'd0, 8'd0, 1'b0, 24'd0, 48'h0000_0000_FFFF},
        '{STEP_ITEM, OP_CORRECT, 8'd255, 8'd0, 8'd0, 1'b1, {8'd255, 8'd0, 8'd0}, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd1, 8'd0, 8'd0, 1'b1, {8'd16, 8'd0, 8'd0}, 48'd0},
        '{STEP_REG, OP_CORRECT, 8'(CFG_ROW_RED), 8'd0, 8'd0, 1'b0, 24'd0, 48'h0000_0000_8000},
        '{STEP_ITEM, OP_CORRECT, 8'd255, 8'd255, 8'd255, 1'b1, {8'd0, 8'd255, 8'd255}, 48'd0},
        '{STEP_REG, OP_CORRECT, 8'(CFG_ROW_GREEN), 8'd0, 8'd0, 1'b0, 24'd0, 48'h7FFF_7FFF_7FFF},
        '{STEP_ITEM, OP_CORRECT, 8'd1, 8'd1, 8'd1, 1'b0, 24'd0, 48'd0},
        '{STEP_ITEM, OP_CORRECT, 8'd0, 8'd0, 8'd0, 1'b1, {8'd0, 8'd0, 8'd0}, 48'd0},
        '{STEP_REG, OP_CORRECT, 8'(CFG_GAMMA_ENABLE), 8'd0, 8'd0, 1'b0, 24'd0,
          48'hFFFF_FFFF_FFFE},
        '{STEP_ITEM, OP_CORRECT, 8'd10, 8'd20, 8'd30, 1'b0, 24'd0, 48'd0}
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    icc_pixel_if  pix ();
    icc_result_if res ();

    isp_color_correction dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix),
        .results   (res)
    );

    gain_t  wb_gain [3];
    row_t   ccm_row [3];
    logic   gamma_on;
    pixel_t gamma_lut [TABLE_DEPTH];
    rgb_t   expected_pixels [$];

    bit valid_held;
    bit send_burst;
    bit take_burst;
    int fails;
    int items_sent;
    int table_writes;
    int pixels_checked;
    int reg_writes;

    always #10 clk = ~clk;

    function automatic pixel_t round_to_level(input longint acc);
        longint lvl;
        if (acc <= 0)
            return '0;
        lvl = (acc + (longint'(1) <<< (SUM_FRAC - 1))) >>> SUM_FRAC;
        if (lvl > PIXEL_MAX)
            lvl = PIXEL_MAX;
        return gamma_on ? gamma_lut[lvl[TABLE_BITS-1:0]] : pixel_t'(lvl);
    endfunction

    function automatic rgb_t correct_pixel(input pixel_t r, input pixel_t g, input pixel_t bl);
        longint wb [3];
        longint acc [3];
        rgb_t   px;
        wb[0] = longint'(r) * longint'(wb_gain[0]);
        wb[1] = longint'(g) * longint'(wb_gain[1]);
        wb[2] = longint'(bl) * longint'(wb_gain[2]);
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = 0;
            for (int j = 0; j < 3; j++)
                acc[k] += longint'($signed(ccm_row[k][COEF_BITS*j +: COEF_BITS])) * wb[j];
        end
        px.red   = round_to_level(acc[0]);
        px.green = round_to_level(acc[1]);
        px.blue  = round_to_level(acc[2]);
        return px;
    endfunction

    function automatic pixel_t pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    function automatic gain_t pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return gain_t'($urandom);
            default: return gain_t'($urandom_range(2048, 8192));
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef(input bit diag);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return diag ? 16'($urandom_range(2048, 6144))
                                 : 16'($urandom_range(0, 2048)) - 16'd1024;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_GAIN_RED:     wb_gain[0] = data[GAIN_BITS-1:0];
            CFG_GAIN_GREEN:   wb_gain[1] = data[GAIN_BITS-1:0];
            CFG_GAIN_BLUE:    wb_gain[2] = data[GAIN_BITS-1:0];
            CFG_ROW_RED:      ccm_row[0] = data[ROW_BITS-1:0];
            CFG_ROW_GREEN:    ccm_row[1] = data[ROW_BITS-1:0];
            CFG_ROW_BLUE:     ccm_row[2] = data[ROW_BITS-1:0];
            CFG_GAMMA_ENABLE: gamma_on = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic drain_pipeline();
        if (valid_held)
        begin
            pix.valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input op_t op, input pixel_t r, input pixel_t g, input pixel_t bl,
                             input tbl_idx_t idx, input pixel_t val,
                             input logic known, input rgb_t want);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            if (valid_held)
                pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.operation   <= op;
        pix.pixel_red   <= r;
        pix.pixel_green <= g;
        pix.pixel_blue  <= bl;
        pix.table_index <= idx;
        pix.table_value <= val;
        valid_held = 1'b1;
        do
            @(posedge clk);
        while (pix.ready !== 1'b1);
        items_sent++;
        if (op == OP_TABLE_WRITE)
        begin
            gamma_lut[idx] = val;
            table_writes++;
        end
        else
            expected_pixels.insert(expected_pixels.size(),
                                   known ? want : correct_pixel(r, g, bl));
    endtask

    initial
    begin : result_sink
        int   stall;
        int   n;
        rgb_t want;
        res.ready <= 1'b0;
        n = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (n % 32 == 0)
                take_burst = ($urandom_range(0, 3) == 0);
            n++;
            stall = take_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (res.valid !== 1'b1);
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel out: %0d %0d %0d",
                       res.out_red, res.out_green, res.out_blue);
                fails++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res.out_red !== want.red)
                begin
                    $error("out_red: expected %0d, actual %0d", want.red, res.out_red);
                    fails++;
                end
                if (res.out_green !== want.green)
                begin
                    $error("out_green: expected %0d, actual %0d", want.green, res.out_green);
                    fails++;
                end
                if (res.out_blue !== want.blue)
                begin
                    $error("out_blue: expected %0d, actual %0d", want.blue, res.out_blue);
                    fails++;
                end
                pixels_checked++;
            end
        end
    end

    initial
    begin : stimulus
        gain_t gains [3];
        row_t  rows [3];
        logic  gamma_sel;
        op_t   op;
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        pix.valid       <= 1'b0;
        pix.operation   <= OP_CORRECT;
        pix.pixel_red   <= '0;
        pix.pixel_green <= '0;
        pix.pixel_blue  <= '0;
        pix.table_index <= '0;
        pix.table_value <= '0;
        wb_gain  = '{3{GAIN_RESET}};
        ccm_row  = '{ROW_RED_RESET, ROW_GREEN_RESET, ROW_BLUE_RESET};
        gamma_on = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == STEP_REG)
            begin
                drain_pipeline();
                write_reg(DIRECTED_PLAN[i].a[CFG_INDEX_BITS-1:0], DIRECTED_PLAN[i].data);
                cfg_wr_en <= 1'b0;
            end
            else if (DIRECTED_PLAN[i].op == OP_TABLE_WRITE)
                send_item(OP_TABLE_WRITE, pick_level(), pick_level(), pick_level(),
                          DIRECTED_PLAN[i].a, DIRECTED_PLAN[i].b, 1'b0, '0);
            else
                send_item(OP_CORRECT, DIRECTED_PLAN[i].a, DIRECTED_PLAN[i].b,
                          DIRECTED_PLAN[i].c, tbl_idx_t'($urandom), pixel_t'($urandom),
                          DIRECTED_PLAN[i].known, DIRECTED_PLAN[i].want);
        end

        // load every gamma entry before gamma can be switched on
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(OP_TABLE_WRITE, pick_level(), pick_level(), pick_level(),
                      tbl_idx_t'(i), pixel_t'($urandom), 1'b0, '0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0, 4:
                begin
                    gains     = '{3{GAIN_RESET}};
                    rows      = '{ROW_RED_RESET, ROW_GREEN_RESET, ROW_BLUE_RESET};
                    gamma_sel = (p == 4);
                end
                1:
                begin
                    gains     = '{3{16'hFFFF}};
                    rows      = '{3{48'h7FFF_7FFF_7FFF}};
                    gamma_sel = 1'b1;
                end
                2:
                begin
                    gains     = '{3{16'h0000}};
                    rows      = '{ROW_RED_RESET, ROW_GREEN_RESET, ROW_BLUE_RESET};
                    gamma_sel = 1'b0;
                end
                3:
                begin
                    gains     = '{3{GAIN_RESET}};
                    rows      = '{3{48'h8000_8000_8000}};
                    gamma_sel = 1'b1;
                end
                default:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        gains[k] = pick_gain();
                        rows[k]  = {pick_coef(k == 2), pick_coef(k == 1), pick_coef(k == 0)};
                    end
                    gamma_sel = 1'($urandom_range(0, 1));
                end
            endcase
            drain_pipeline();
            write_reg(CFG_GAIN_RED, {$urandom, gains[0]});
            write_reg(CFG_GAIN_GREEN, {$urandom, gains[1]});
            write_reg(CFG_GAIN_BLUE, {$urandom, gains[2]});
            write_reg(CFG_ROW_RED, rows[0]);
            write_reg(CFG_ROW_GREEN, rows[1]);
            write_reg(CFG_ROW_BLUE, rows[2]);
            write_reg(CFG_GAMMA_ENABLE, {47'({$urandom, $urandom}), gamma_sel});
            cfg_wr_en <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 32 == 0)
                    send_burst = ($urandom_range(0, 3) == 0);
                op = ($urandom_range(0, 99) < 15) ? OP_TABLE_WRITE : OP_CORRECT;
                send_item(op, pick_level(), pick_level(), pick_level(),
                          tbl_idx_t'($urandom), pixel_t'($urandom), 1'b0, '0);
            end
        end

        drain_pipeline();
        $display("%0d items accepted, %0d of them gamma-table writes; %0d pixels checked",
                 items_sent, table_writes, pixels_checked);
        $display("%0d register writes over %0d settings, gain and coefficient extremes included",
                 reg_writes, NUM_PHASES + 6);
        if (fails == 0 && expected_pixels.size() == 0)
            $display("[isp_color_correction] OK");
        else
            $display("[isp_color_correction] ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $error("timed out with %0d pixels pending", expected_pixels.size());
        $display("[isp_color_correction] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/icc_pkg.sv
rtl/icc_if.sv
rtl/isp_color_correction.sv
tb/tb.sv
